>>> src/srb_pkg.sv
// Shared types and constants for the sequence reorder buffer.
package srb_pkg;

    localparam int DEPTH    = 32;                   // slot count, a power of two
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SEQ_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W  = 32;                 // seq_number, msg_handle
    localparam int OUT_DATA_W = 40;                 // out_handle, out_seq, resync_seen, pad

    localparam logic [MODE_W-1:0] MODE_MSG   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SYNC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_RELEASED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUFFERED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_COLLISION = 2'd3;

    localparam logic [SEQ_W-1:0] SEQ_ONE  = 16'd1;
    localparam logic [SEQ_W-1:0] SEQ_ZERO = 16'd0;
    localparam logic [SEQ_W-1:0] SEQ_MAX  = 16'hFFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;        // input transaction taken this cycle
        logic lookup;         // classify the captured message, start slot read
        logic release_step;   // emit one released result, advance the drain
        logic store_step;     // emit the buffered or dropped result
    } srb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_msg;      // the offered input transaction is a message
        logic in_order;       // captured message is released at once
        logic more_ok;        // the drain continues after this result
        logic out_free;       // output register can take a result
    } srb_stat_t;

endpackage

>>> src/srb_ctrl.sv
// Controller state machine of the sequence reorder buffer.
module srb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  srb_pkg::srb_stat_t stat,
    output srb_pkg::srb_cmd_t  cmd
);
    import srb_pkg::*;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_LOOKUP  = 2'd1;
    localparam logic [1:0] S_RELEASE = 2'd2;
    localparam logic [1:0] S_STORE   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (stat.in_is_msg) begin
                        state_next = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = stat.in_order ? S_RELEASE : S_STORE;
            end
            S_RELEASE: begin
                if (stat.out_free) begin
                    cmd.release_step = 1'b1;
                    if (!stat.more_ok) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_STORE: begin
                if (stat.out_free) begin
                    cmd.store_step = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/srb_datapath.sv
// Datapath of the sequence reorder buffer: sequence state, slot table, output register.
module srb_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [srb_pkg::MODE_W-1:0]    s_tuser,
    input  logic [srb_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [srb_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [srb_pkg::STATUS_W-1:0]  m_tuser,
    output logic                          m_tlast,
    input  srb_pkg::srb_cmd_t             cmd,
    output srb_pkg::srb_stat_t            stat
);
    import srb_pkg::*;

    // Sequence state.
    logic [SEQ_W-1:0]    expected_seq_reg;
    logic [SEQ_W-1:0]    expected_seq_next;
    logic [SEQ_W-1:0]    expected_inc;
    logic                resync_pending_reg;
    logic                first_cycle_reg;
    logic                resync_flag_reg;
    logic [DEPTH-1:0]    slot_valid_reg;

    // Captured message and the item being released.
    logic [SEQ_W-1:0]    in_seq_reg;
    logic [HANDLE_W-1:0] in_handle_reg;
    logic [SEQ_W-1:0]    cur_seq_reg;
    logic [HANDLE_W-1:0] cur_handle_reg;
    logic [CNT_W-1:0]    count_reg;

    // Slot table.
    logic [SEQ_W-1:0]    mem_seq    [DEPTH];
    logic [HANDLE_W-1:0] mem_handle [DEPTH];
    logic [SEQ_W-1:0]    rd_seq_reg;
    logic [HANDLE_W-1:0] rd_handle_reg;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;

    // Output register.
    logic                out_valid_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [SEQ_W-1:0]    out_seq_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_resync_reg;
    logic                out_last_reg;

    logic [IDX_W-1:0]    in_idx;
    logic [IDX_W-1:0]    exp_idx;
    logic                in_order;
    logic                more;
    logic                out_free;
    logic                resync_now;

    assign in_idx   = in_seq_reg[IDX_W-1:0];
    assign exp_idx  = expected_seq_reg[IDX_W-1:0];
    assign in_order = (in_seq_reg == expected_seq_reg) || (in_seq_reg == SEQ_ZERO);
    assign more     = slot_valid_reg[exp_idx] && (rd_seq_reg == expected_seq_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign expected_inc = (expected_seq_reg == SEQ_MAX) ? SEQ_ONE : expected_seq_reg + SEQ_ONE;
    assign resync_now   = cmd.capture && (s_tuser == MODE_MSG) && resync_pending_reg;

    assign stat.in_is_msg = (s_tuser == MODE_MSG);
    assign stat.in_order  = in_order;
    assign stat.more_ok   = more && (count_reg < CNT_W'(DEPTH));
    assign stat.out_free  = out_free;

    always_comb begin
        expected_seq_next = expected_seq_reg;
        if (resync_now) begin
            expected_seq_next = SEQ_ONE;
        end else if ((cmd.lookup && in_order) || (cmd.release_step && stat.more_ok)) begin
            expected_seq_next = expected_inc;
        end
    end

    always_comb begin
        rd_en   = cmd.lookup || (cmd.release_step && stat.more_ok);
        rd_addr = in_idx;
        if ((cmd.lookup && in_order) || cmd.release_step) begin
            rd_addr = expected_inc[IDX_W-1:0];
        end
        wr_en = cmd.store_step && !slot_valid_reg[in_idx];
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_seq_reg    <= mem_seq[rd_addr];
            rd_handle_reg <= mem_handle[rd_addr];
        end
        if (wr_en) begin
            mem_seq[in_idx]    <= in_seq_reg;
            mem_handle[in_idx] <= in_handle_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_seq_reg   <= SEQ_ONE;
            resync_pending_reg <= 1'b0;
            first_cycle_reg    <= 1'b1;
            resync_flag_reg    <= 1'b0;
            slot_valid_reg     <= '0;
            out_valid_reg      <= 1'b0;
            count_reg          <= '0;
        end else begin
            expected_seq_reg <= expected_seq_next;
            if (cmd.capture) begin
                if (s_tuser == MODE_SYNC) begin
                    resync_pending_reg <= 1'b1;
                end else if (s_tuser == MODE_CLEAR) begin
                    resync_pending_reg <= 1'b0;
                end
            end
            if (resync_now) begin
                resync_pending_reg <= 1'b0;
                slot_valid_reg     <= '0;
                if (first_cycle_reg) begin
                    first_cycle_reg <= 1'b0;
                end else begin
                    resync_flag_reg <= 1'b1;
                end
            end
            if (cmd.lookup) begin
                count_reg <= '0;
            end
            if (cmd.release_step) begin
                count_reg <= count_reg + CNT_W'(1);
                if (stat.more_ok) begin
                    slot_valid_reg[exp_idx] <= 1'b0;
                end
            end
            if (wr_en) begin
                slot_valid_reg[in_idx] <= 1'b1;
            end
            if (cmd.release_step || cmd.store_step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_seq_reg    <= s_tdata[SEQ_W-1:0];
            in_handle_reg <= s_tdata[SEQ_W +: HANDLE_W];
        end
        if (cmd.lookup) begin
            cur_seq_reg    <= in_seq_reg;
            cur_handle_reg <= in_handle_reg;
        end else if (cmd.release_step && stat.more_ok) begin
            cur_seq_reg    <= rd_seq_reg;
            cur_handle_reg <= rd_handle_reg;
        end
        if (cmd.release_step) begin
            out_handle_reg <= cur_handle_reg;
            out_seq_reg    <= cur_seq_reg;
            out_status_reg <= ST_RELEASED;
            out_resync_reg <= resync_flag_reg;
            out_last_reg   <= !more;
        end else if (cmd.store_step) begin
            out_handle_reg <= in_handle_reg;
            out_seq_reg    <= in_seq_reg;
            out_resync_reg <= resync_flag_reg;
            out_last_reg   <= 1'b1;
            if (!slot_valid_reg[in_idx]) begin
                out_status_reg <= ST_BUFFERED;
            end else if (rd_seq_reg == in_seq_reg) begin
                out_status_reg <= ST_DUPLICATE;
            end else begin
                out_status_reg <= ST_COLLISION;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_DATA_W - SEQ_W - HANDLE_W - 1){1'b0}},
                       out_resync_reg, out_seq_reg, out_handle_reg};

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.release_step || cmd.store_step) |-> out_free)
        else $error("result loaded while output register is still full");

    // The expected sequence number never takes the value zero.
    a_expected_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        expected_seq_reg != SEQ_ZERO)
        else $error("expected sequence reached zero");

    // A buffered message leaves its slot marked valid.
    a_store_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> slot_valid_reg[$past(in_idx)])
        else $error("stored slot not marked valid");

    // A drained slot is freed.
    a_drain_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.release_step && stat.more_ok) |=> !slot_valid_reg[$past(exp_idx)])
        else $error("drained slot still valid");

endmodule

>>> src/sequence_reorder_buffer_unit.sv
// Top level of the sequence reorder buffer: controller plus datapath.
//
// This block resequences messages by their 16-bit sequence number. Each input
// transaction is a message, a sync request or a clear request, selected by
// s_tuser. A sync request arms a resync and a clear request disarms it; neither
// produces a result. A message that arrives with a resync armed restarts the
// expected sequence at 1 and empties the slot table first; every resync after
// the first one sets the sticky resync_seen flag. A message whose number equals
// the expected one, or is 0, is released with status 0, after which buffered
// successors are drained in order, one result transaction each, with m_tlast on
// the final result of that message. Any other message is parked in a
// direct-mapped table of 32 slots indexed by the low five bits of its number
// and answered with status 1; if the slot is taken the message is dropped with
// status 2 (same number) or 3 (different number). The expected sequence wraps
// from 65535 to 1. A sync, clear or unused-mode transaction is handled in the
// accept step alone; a message is accepted, then looked up in the slot table,
// then its results are emitted one after another, each waiting while the
// output is stalled. The block takes no new transaction until the last result
// of a message is loaded. Each drain step reads the slot of the next expected
// number through the single read port of the slot table. A finished result
// waits in the output register while the next transaction is accepted. There
// is no clearing pass after reset.
module sequence_reorder_buffer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [srb_pkg::IN_DATA_W-1:0]  s_tdata,   // [15:0] seq_number, [31:16] msg_handle
    input  logic [srb_pkg::MODE_W-1:0]     s_tuser,   // [1:0] mode
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [srb_pkg::OUT_DATA_W-1:0] m_tdata,   // [15:0] out_handle, [31:16] out_seq,
                                                      // [32] resync_seen, [39:33] zero
    output logic [srb_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
    output logic                           m_tlast    // last result of this message
);
    import srb_pkg::*;

    srb_cmd_t  cmd;
    srb_stat_t stat;

    // The controller sequences accept, lookup and the release or store steps.
    srb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the sequence state, the slot table and the result register.
    srb_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
